// ----- rtl/gmc_pkg.sv -----
// Package for the gate motor controller.
// Holds the gate state codes, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package gmc_pkg;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_ERROR   = 3'd1,
    MODE_CLOSED  = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_CLOSING = 3'd4,
    MODE_OPENING = 3'd5
  } gate_mode_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_TRAVEL_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_HALF     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_IVL     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] TRAVEL_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] BLINK_HALF_RST     = 16'd500;
  localparam logic [CFG_DATA_W-1:0] SAMPLE_IVL_RST     = 16'd100;

  // Active-low switch samples of one tick.
  typedef struct packed {
    logic button_n;
    logic closed_limit_n;
    logic open_limit_n;
  } gmc_sample_t;

  // Thresholds taken from the configuration registers.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] travel_timeout;
    logic [CFG_DATA_W-1:0] blink_half;
    logic [CFG_DATA_W-1:0] sample_ivl;
  } gmc_cfg_t;

endpackage

// ----- rtl/gmc_cfg.sv -----
// Configuration register file of the gate motor controller.
// Depends on gmc_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module gmc_cfg
  import gmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output gmc_cfg_t               cfg
);

  gmc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.travel_timeout <= TRAVEL_TIMEOUT_RST;
      cfg_r.blink_half     <= BLINK_HALF_RST;
      cfg_r.sample_ivl     <= SAMPLE_IVL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRAVEL_TIMEOUT: cfg_r.travel_timeout <= cfg_data;
        CFG_BLINK_HALF:     cfg_r.blink_half     <= cfg_data;
        CFG_SAMPLE_IVL:     cfg_r.sample_ivl     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/gmc_step.sv -----
// Next-state logic for one tick of the gate motor controller.
// Depends on gmc_pkg for the state codes, sample and configuration structs.
`timescale 1ns / 1ps

module gmc_step
  import gmc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  gmc_sample_t            smp,
  input  gmc_cfg_t               cfg,
  input  gate_mode_t             mode,
  input  logic [COUNT_WIDTH-1:0] sample_cnt,
  input  logic [COUNT_WIDTH-1:0] travel_cnt,
  input  logic                   travel_run,
  input  logic [COUNT_WIDTH-1:0] blink_cnt,
  input  logic                   yellow,
  output gate_mode_t             mode_nxt,
  output logic [COUNT_WIDTH-1:0] sample_cnt_nxt,
  output logic [COUNT_WIDTH-1:0] travel_cnt_nxt,
  output logic                   travel_run_nxt,
  output logic [COUNT_WIDTH-1:0] blink_cnt_nxt,
  output logic                   yellow_nxt
);

  localparam int unsigned EXT_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    bump = (&c) ? c : c + 1'b1;
  endfunction

  // A zero threshold acts as one. A threshold beyond the counter range is reached
  // once the counter saturates, so no explicit clamp is needed.
  function automatic logic hit(input logic [COUNT_WIDTH-1:0] c,
                               input logic [CFG_DATA_W-1:0]  thr);
    logic [EXT_W-1:0] c_ext;
    logic [EXT_W-1:0] t_ext;
    c_ext = EXT_W'(c);
    t_ext = (thr == '0) ? EXT_W'(1) : EXT_W'(thr);
    hit = (c_ext >= t_ext) || (&c);
  endfunction

  logic pressed;
  logic cl;
  logic op;

  assign pressed = !smp.button_n;
  assign cl      = !smp.closed_limit_n;
  assign op      = !smp.open_limit_n;

  always_comb begin
    gate_mode_t             m;
    logic [COUNT_WIDTH-1:0] tc;
    logic                   run;
    logic [COUNT_WIDTH-1:0] bc;
    logic [COUNT_WIDTH-1:0] sc;
    logic                   yl;

    m   = mode;
    tc  = travel_cnt;
    run = travel_run;
    yl  = yellow;

    if (travel_run) begin
      tc = bump(travel_cnt);
      if (hit(tc, cfg.travel_timeout)) begin
        run = 1'b0;
        m   = MODE_ERROR;
      end
    end

    bc = bump(blink_cnt);
    sc = bump(sample_cnt);

    if (hit(sc, cfg.sample_ivl)) begin
      sc = '0;
      case (m)
        MODE_ERROR: begin
          if (hit(bc, cfg.blink_half)) begin
            yl = !yl;
            bc = '0;
          end
          if (pressed) m = MODE_START;
        end
        MODE_CLOSED: begin
          yl = 1'b0;
          if (pressed) begin
            m   = MODE_OPENING;
            tc  = '0;
            run = 1'b1;
          end
        end
        MODE_OPEN: begin
          yl = 1'b0;
          if (pressed) begin
            m   = MODE_CLOSING;
            tc  = '0;
            run = 1'b1;
          end
        end
        MODE_CLOSING: begin
          yl = 1'b0;
          if (cl && op) begin
            m   = MODE_ERROR;
            run = 1'b0;
          end else if (cl) begin
            m   = MODE_CLOSED;
            run = 1'b0;
          end
        end
        MODE_OPENING: begin
          yl = 1'b0;
          if (cl && op) begin
            m   = MODE_ERROR;
            run = 1'b0;
          end else if (op) begin
            m   = MODE_OPEN;
            run = 1'b0;
          end
        end
        default: begin
          // Start, and any unused code, decides from the limit switches.
          if (cl && op) begin
            m = MODE_ERROR;
          end else if (cl) begin
            m = MODE_CLOSED;
          end else begin
            m   = MODE_CLOSING;
            tc  = '0;
            run = 1'b1;
          end
        end
      endcase
    end

    mode_nxt       = m;
    sample_cnt_nxt = sc;
    travel_cnt_nxt = tc;
    travel_run_nxt = run;
    blink_cnt_nxt  = bc;
    yellow_nxt     = yl;
  end

endmodule

// ----- rtl/gate_motor_controller.sv -----
// Gate motor controller top level: input register, state update and result register.
// Depends on gmc_pkg, gmc_cfg and gmc_step.
// Each input transaction is one 1 ms tick with the active-low button and limit switches;
// each tick yields exactly one result transaction with the motor drives, the lamps and the
// gate state after that tick. One tick is accepted every clock cycle unless in_stall is
// raised by a stalled result. Each accepted tick passes through the input register, then
// the state update into the result register, from which its result is offered.
// A stalled result holds both stages. Configuration registers are to be written only
// while no tick is in flight; the user is bound by this, the block does not enforce it.
`timescale 1ns / 1ps

module gate_motor_controller
  import gmc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_button_n,
  input  logic                   in_closed_limit_n,
  input  logic                   in_open_limit_n,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_motor_open,
  output logic                   out_motor_close,
  output logic                   out_led_red,
  output logic                   out_led_blue,
  output logic                   out_led_yellow,
  output logic [2:0]             out_gate_state
);

  gmc_cfg_t cfg;

  gmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic        adv;
  logic        in_vld_r;
  gmc_sample_t smp_r;
  logic        out_vld_r;
  gate_mode_t  out_mode_r;
  logic        out_yellow_r;

  gate_mode_t             mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] sample_cnt_r, sample_cnt_nxt;
  logic [COUNT_WIDTH-1:0] travel_cnt_r, travel_cnt_nxt;
  logic                   travel_run_r, travel_run_nxt;
  logic [COUNT_WIDTH-1:0] blink_cnt_r, blink_cnt_nxt;
  logic                   yellow_r, yellow_nxt;

  // Both stages move together whenever the result register is free or being taken.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  gmc_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .smp            (smp_r),
    .cfg            (cfg),
    .mode           (mode_r),
    .sample_cnt     (sample_cnt_r),
    .travel_cnt     (travel_cnt_r),
    .travel_run     (travel_run_r),
    .blink_cnt      (blink_cnt_r),
    .yellow         (yellow_r),
    .mode_nxt       (mode_nxt),
    .sample_cnt_nxt (sample_cnt_nxt),
    .travel_cnt_nxt (travel_cnt_nxt),
    .travel_run_nxt (travel_run_nxt),
    .blink_cnt_nxt  (blink_cnt_nxt),
    .yellow_nxt     (yellow_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      mode_r       <= MODE_START;
      sample_cnt_r <= '0;
      travel_cnt_r <= '0;
      travel_run_r <= 1'b0;
      blink_cnt_r  <= '0;
      yellow_r     <= 1'b0;
    end else if (adv) begin
      in_vld_r  <= in_valid;
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        mode_r       <= mode_nxt;
        sample_cnt_r <= sample_cnt_nxt;
        travel_cnt_r <= travel_cnt_nxt;
        travel_run_r <= travel_run_nxt;
        blink_cnt_r  <= blink_cnt_nxt;
        yellow_r     <= yellow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_r.button_n       <= in_button_n;
      smp_r.closed_limit_n <= in_closed_limit_n;
      smp_r.open_limit_n   <= in_open_limit_n;
      out_mode_r           <= mode_nxt;
      out_yellow_r         <= yellow_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_motor_open  = (out_mode_r == MODE_OPENING);
  assign out_motor_close = (out_mode_r == MODE_CLOSING);
  assign out_led_red     = (out_mode_r == MODE_CLOSED);
  assign out_led_blue    = (out_mode_r == MODE_OPEN);
  assign out_led_yellow  = (out_mode_r == MODE_ERROR) && out_yellow_r;
  assign out_gate_state  = out_mode_r;

endmodule
